FILE: hdl/mrsp_pkg.sv
// Package for the MIDI running status parser.
// Holds the byte class codes, MIDI status constants and the result record.
// No dependencies.
package mrsp_pkg;

    typedef enum logic [3:0] {
        CLS_CHAN_STATUS    = 4'd0,
        CLS_DATA           = 4'd1,
        CLS_DATA_NO_STATUS = 4'd2,
        CLS_CLOCK          = 4'd3,
        CLS_SYS_COMMON     = 4'd4,
        CLS_SYSEX_BEGIN    = 4'd5,
        CLS_SYSEX_END      = 4'd6,
        CLS_OTHER_SYSTEM   = 4'd7,
        CLS_SYSEX_DATA     = 4'd8
    } byte_class_t;

    localparam logic [7:0] SYSTEM_NIBBLE = 8'hF0;
    localparam logic [7:0] SYSEX_START   = 8'hF0;
    localparam logic [7:0] SYSEX_STOP    = 8'hF7;
    localparam logic [7:0] MTC_QUARTER   = 8'hF1;
    localparam logic [7:0] SONG_POSITION = 8'hF2;
    localparam logic [7:0] SONG_SELECT   = 8'hF3;
    localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
    localparam logic [7:0] MIDI_START    = 8'hFA;
    localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
    localparam logic [7:0] MIDI_STOP     = 8'hFC;
    localparam logic [7:0] NOTE_OFF_HI   = 8'h80;
    localparam logic [7:0] NOTE_ON_HI    = 8'h90;
    localparam logic [7:0] PROG_CHG_HI   = 8'hC0;
    localparam logic [7:0] CHAN_PRESS_HI = 8'hD0;
    localparam logic [7:0] NO_STATUS     = 8'h00;

    typedef struct packed {
        logic [7:0]  out_byte;
        byte_class_t byte_class;
        logic [7:0]  running_status;
        logic        param_position;
        logic        note_key_byte;
        logic        message_complete;
        logic        sysex_active;
    } result_t;

endpackage

FILE: hdl/midi_running_status_parser.sv
// MIDI running status parser, top level.
// Classifies each received MIDI byte and tracks running status and sysex state.
// Depends on mrsp_pkg.
//
// Usage: the input channel (in_valid, in_stall, rx_byte) takes one received
// MIDI byte per item. The output channel (out_valid, out_stall and the result
// fields) returns exactly one result item for each input item, in order.
// A byte is first captured in an input register; the classification logic
// then reads it together with the parser state, updates the state and loads
// the result register and sets out_valid, as soon as the result register is
// empty or the receiver does not stall. The block sustains one item per cycle
// while the receiver does not stall, set by the single pass from the input
// register through the classifier to the result register.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; in_stall rises only when both are
// full. Reset clears the running status, the parameter counters, the sysex
// flag and both valid flags, so the block is empty and ready after reset.
module midi_running_status_parser
    import mrsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [3:0] byte_class,
    output logic [7:0] running_status_out,
    output logic       param_position,
    output logic       note_key_byte,
    output logic       message_complete,
    output logic       sysex_active
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;

    logic [7:0]  running_status_reg;
    logic [7:0]  running_status_next;
    logic [1:0]  params_needed_reg;
    logic [1:0]  params_needed_next;
    logic        params_received_reg;
    logic        params_received_next;
    logic        in_sysex_reg;
    logic        in_sysex_next;

    logic        stage_move;
    logic        in_accept;
    logic [7:0]  status_hi;
    logic [7:0]  byte_hi;
    logic [1:0]  next_count;

    assign stage_move = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = in_valid_reg && !stage_move;
    assign in_accept  = in_valid && !in_stall;

    assign byte_hi    = in_byte_reg & SYSTEM_NIBBLE;
    assign status_hi  = running_status_reg & SYSTEM_NIBBLE;
    assign next_count = {1'b0, params_received_reg} + 2'd1;

    always_comb
    begin
        running_status_next  = running_status_reg;
        params_needed_next   = params_needed_reg;
        params_received_next = params_received_reg;
        in_sysex_next        = in_sysex_reg;
        result_next.out_byte         = in_byte_reg;
        result_next.byte_class       = CLS_OTHER_SYSTEM;
        result_next.param_position   = 1'b0;
        result_next.note_key_byte    = 1'b0;
        result_next.message_complete = 1'b0;

        if (byte_hi == SYSTEM_NIBBLE)
        begin
            case (in_byte_reg) inside
                MIDI_CLOCK, MIDI_START, MIDI_CONTINUE, MIDI_STOP:
                begin
                    result_next.byte_class = CLS_CLOCK;
                end
                MTC_QUARTER, SONG_POSITION, SONG_SELECT:
                begin
                    result_next.byte_class = CLS_SYS_COMMON;
                    running_status_next    = in_byte_reg;
                    params_received_next   = 1'b0;
                    params_needed_next     = (in_byte_reg == SONG_POSITION) ? 2'd2 : 2'd1;
                    in_sysex_next          = 1'b0;
                end
                SYSEX_START:
                begin
                    result_next.byte_class = CLS_SYSEX_BEGIN;
                    in_sysex_next          = 1'b1;
                end
                SYSEX_STOP:
                begin
                    result_next.byte_class = CLS_SYSEX_END;
                    in_sysex_next          = 1'b0;
                end
                default:
                begin
                    result_next.byte_class = CLS_OTHER_SYSTEM;
                end
            endcase
        end
        else if (in_byte_reg[7])
        begin
            result_next.byte_class = CLS_CHAN_STATUS;
            in_sysex_next          = 1'b0;
            params_received_next   = 1'b0;
            running_status_next    = in_byte_reg;
            params_needed_next     = (byte_hi == PROG_CHG_HI || byte_hi == CHAN_PRESS_HI)
                                     ? 2'd1 : 2'd2;
        end
        else if (in_sysex_reg)
        begin
            result_next.byte_class = CLS_SYSEX_DATA;
        end
        else if (running_status_reg != NO_STATUS)
        begin
            result_next.byte_class     = CLS_DATA;
            result_next.param_position = params_received_reg;
            result_next.note_key_byte  = (status_hi == NOTE_OFF_HI || status_hi == NOTE_ON_HI)
                                         && !params_received_reg;
            if (next_count >= params_needed_reg)
            begin
                result_next.message_complete = 1'b1;
                params_received_next         = 1'b0;
            end
            else
            begin
                params_received_next = next_count[0];
            end
        end
        else
        begin
            result_next.byte_class = CLS_DATA_NO_STATUS;
        end

        result_next.running_status = running_status_next;
        result_next.sysex_active   = in_sysex_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            running_status_reg  <= NO_STATUS;
            params_needed_reg   <= 2'd0;
            params_received_reg <= 1'b0;
            in_sysex_reg        <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (stage_move)
            begin
                in_valid_reg <= 1'b0;
            end

            if (stage_move)
            begin
                out_valid_reg       <= 1'b1;
                running_status_reg  <= running_status_next;
                params_needed_reg   <= params_needed_next;
                params_received_reg <= params_received_next;
                in_sysex_reg        <= in_sysex_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (stage_move)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_byte           = result_reg.out_byte;
    assign byte_class         = result_reg.byte_class;
    assign running_status_out = result_reg.running_status;
    assign param_position     = result_reg.param_position;
    assign note_key_byte      = result_reg.note_key_byte;
    assign message_complete   = result_reg.message_complete;
    assign sysex_active       = result_reg.sysex_active;

endmodule
